@@ hdl/rfa_pkg.sv @@
// Shared constants for the reduced fraction ALU: field widths, mode and order codes.
`default_nettype none

package rfa_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int MODE_W            = 3;
  localparam int ORDER_W           = 2;
  localparam int RESULT_NUM_W      = 32;
  localparam int RESULT_DEN_W      = 31;

  localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CMP = 3'd4;

  localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd2;

endpackage

`default_nettype wire

@@ hdl/reduced_fraction_alu.sv @@
// Top level of the reduced fraction ALU: sequencer, shared multiplier and shared adder.
`default_nettype none

// The block takes one word of two signed fractions and a mode, and returns one
// result word: the sum, difference, product or quotient reduced to lowest terms
// with a positive denominator, or for compare the order of the two fractions.
// A zero numerator comes back as 0/1, a zero result denominator raises
// div_error with 0/0, and unused modes return all zeros. Results wider than the
// output fields wrap to them. The block works on one word at a time and holds
// in_stall high until that word has reached the output register; the result
// waits there while the next word is already being taken in. All work runs
// through one signed multiplier and one adder/subtractor of 2*OPERAND_WIDTH+1
// bits. A word passes through the multiply states S_MUL1 to S_MUL3, an add,
// a check, the sign states S_ABS_A and S_ABS_B, a binary GCD loop (one shift,
// subtract or swap per cycle), two restoring divisions by the GCD, a sign
// state and an output state. Compare goes to the output after the add, zero
// numerators and errors after the check, and unused modes after S_MUL1.
module reduced_fraction_alu #(
  parameter int OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire        [rfa_pkg::MODE_W-1:0]      in_mode,
  input  wire signed [OPERAND_WIDTH-1:0]        in_left_num,
  input  wire        [OPERAND_WIDTH-2:0]        in_left_den,
  input  wire signed [OPERAND_WIDTH-1:0]        in_right_num,
  input  wire        [OPERAND_WIDTH-2:0]        in_right_den,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [rfa_pkg::RESULT_NUM_W-1:0] out_result_num,
  output logic        [rfa_pkg::RESULT_DEN_W-1:0] out_result_den,
  output logic        [rfa_pkg::ORDER_W-1:0]      out_order,
  output logic                                  out_div_error
);

  // Products and sums are exact in 2W signed bits; one extra bit lets the
  // adder's sign show the outcome of a compare or a trial subtraction.
  localparam int W   = OPERAND_WIDTH;
  localparam int MW  = 2 * W;
  localparam int AW  = MW + 1;
  localparam int PW  = 2 * W + 2;
  localparam int CW  = $clog2(MW + 1);
  localparam int EXT = (AW > rfa_pkg::RESULT_NUM_W) ? AW : rfa_pkg::RESULT_NUM_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_ADD,
    S_CHECK,
    S_ABS_A,
    S_ABS_B,
    S_GCD,
    S_DIV_N,
    S_DIV_D,
    S_NEG,
    S_DONE
  } state_t;

  state_t state_r;

  // Captured operands.
  logic [rfa_pkg::MODE_W-1:0] mode_r;
  logic [W-1:0]               ln_r;
  logic [W-2:0]               ld_r;
  logic [W-1:0]               rn_r;
  logic [W-2:0]               rd_r;

  // Working registers. a_r holds the numerator, the GCD operand and the
  // division remainder in turn; b_r the denominator, the other GCD operand
  // and the dividend/quotient.
  logic signed [AW-1:0]       a_r;
  logic signed [AW-1:0]       b_r;
  logic signed [AW-1:0]       d_r;
  logic [MW-1:0]              keep_num_r;
  logic [MW-1:0]              keep_den_r;
  logic [MW-1:0]              g_r;
  logic [CW-1:0]              k_r;
  logic [CW-1:0]              cnt_r;
  logic                       neg_r;
  logic                       err_r;
  logic [rfa_pkg::ORDER_W-1:0] order_r;

  logic                       out_valid_r;
  logic signed [rfa_pkg::RESULT_NUM_W-1:0] out_result_num_r;
  logic [rfa_pkg::RESULT_DEN_W-1:0]        out_result_den_r;
  logic [rfa_pkg::ORDER_W-1:0]             out_order_r;
  logic                                    out_div_error_r;

  // Shared multiplier.
  logic signed [W:0]    mul_a;
  logic signed [W:0]    mul_b;
  logic signed [PW-1:0] prod;

  // Shared adder/subtractor.
  logic signed [AW-1:0] as_a;
  logic signed [AW-1:0] as_b;
  logic                 as_sub;
  logic signed [AW-1:0] as_res;

  logic                 q_bit;
  logic [MW-1:0]        q_next;
  logic signed [EXT-1:0] num_ext;
  logic signed [EXT-1:0] den_ext;

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_result_num = out_result_num_r;
  assign out_result_den = out_result_den_r;
  assign out_order      = out_order_r;
  assign out_div_error  = out_div_error_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL1: begin
        mul_a = $signed({ln_r[W-1], ln_r});
        mul_b = (mode_r == rfa_pkg::MODE_MUL) ? $signed({rn_r[W-1], rn_r})
                                              : $signed({2'b00, rd_r});
      end
      S_MUL2: begin
        mul_a = $signed({2'b00, ld_r});
        mul_b = $signed({rn_r[W-1], rn_r});
      end
      S_MUL3: begin
        mul_a = $signed({2'b00, ld_r});
        mul_b = $signed({2'b00, rd_r});
      end
      default: begin
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    as_a   = '0;
    as_b   = '0;
    as_sub = 1'b1;
    unique case (state_r) inside
      S_ADD: begin
        as_a   = a_r;
        as_b   = b_r;
        as_sub = (mode_r != rfa_pkg::MODE_ADD);
      end
      S_ABS_A: as_b = a_r;
      S_ABS_B: as_b = b_r;
      S_GCD: begin
        as_a = a_r;
        as_b = b_r;
      end
      S_DIV_N, S_DIV_D: begin
        as_a = $signed({a_r[MW-1:0], b_r[MW-1]});
        as_b = $signed({1'b0, g_r});
      end
      S_NEG: as_b = $signed({1'b0, keep_num_r});
      default: begin
      end
    endcase
    as_res = as_sub ? (as_a - as_b) : (as_a + as_b);
  end

  // Restoring division step: a non-negative trial keeps the subtraction.
  assign q_bit   = ~as_res[AW-1];
  assign q_next  = {b_r[MW-2:0], q_bit};
  assign num_ext = EXT'(a_r);
  assign den_ext = EXT'(b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the output register is reloaded instead whenever it frees up.
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_mode;
            ln_r    <= in_left_num;
            ld_r    <= in_left_den;
            rn_r    <= in_right_num;
            rd_r    <= in_right_den;
            err_r   <= 1'b0;
            order_r <= rfa_pkg::ORDER_LESS;
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (mode_r > rfa_pkg::MODE_CMP) begin
            a_r     <= '0;
            b_r     <= '0;
            state_r <= S_DONE;
          end else begin
            a_r     <= prod[AW-1:0];
            state_r <= S_MUL2;
          end
        end
        S_MUL2: begin
          b_r     <= prod[AW-1:0];
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          d_r     <= prod[AW-1:0];
          state_r <= S_ADD;
        end
        S_ADD: begin
          case (mode_r) inside
            rfa_pkg::MODE_CMP: begin
              if (as_res[AW-1]) begin
                order_r <= rfa_pkg::ORDER_LESS;
              end else if (as_res == '0) begin
                order_r <= rfa_pkg::ORDER_EQUAL;
              end else begin
                order_r <= rfa_pkg::ORDER_GREATER;
              end
              a_r     <= '0;
              b_r     <= '0;
              state_r <= S_DONE;
            end
            rfa_pkg::MODE_ADD, rfa_pkg::MODE_SUB: begin
              a_r     <= as_res;
              b_r     <= d_r;
              state_r <= S_CHECK;
            end
            rfa_pkg::MODE_MUL: begin
              b_r     <= d_r;
              state_r <= S_CHECK;
            end
            default: begin
              state_r <= S_CHECK;
            end
          endcase
        end
        S_CHECK: begin
          if (b_r == '0) begin
            a_r     <= '0;
            err_r   <= 1'b1;
            state_r <= S_DONE;
          end else if (a_r == '0) begin
            b_r     <= AW'(1);
            state_r <= S_DONE;
          end else begin
            neg_r   <= a_r[AW-1] ^ b_r[AW-1];
            state_r <= S_ABS_A;
          end
        end
        S_ABS_A: begin
          if (a_r[AW-1]) begin
            a_r <= as_res;
          end
          state_r <= S_ABS_B;
        end
        S_ABS_B: begin
          if (b_r[AW-1]) begin
            b_r        <= as_res;
            keep_den_r <= as_res[MW-1:0];
          end else begin
            keep_den_r <= b_r[MW-1:0];
          end
          keep_num_r <= a_r[MW-1:0];
          k_r        <= '0;
          state_r    <= S_GCD;
        end
        S_GCD: begin
          // Binary GCD: strip common twos, then odd-odd subtraction, with a
          // swap whenever the smaller value sits in a_r.
          if (a_r == b_r) begin
            g_r     <= a_r[MW-1:0] << k_r;
            a_r     <= '0;
            b_r     <= $signed({1'b0, keep_num_r});
            cnt_r   <= '0;
            state_r <= S_DIV_N;
          end else if (!a_r[0] && !b_r[0]) begin
            a_r <= a_r >>> 1;
            b_r <= b_r >>> 1;
            k_r <= CW'(k_r + 1'b1);
          end else if (!a_r[0]) begin
            a_r <= a_r >>> 1;
          end else if (!b_r[0]) begin
            b_r <= b_r >>> 1;
          end else if (as_res[AW-1]) begin
            a_r <= b_r;
            b_r <= a_r;
          end else begin
            a_r <= as_res >>> 1;
          end
        end
        S_DIV_N: begin
          if (cnt_r == CW'(MW - 1)) begin
            keep_num_r <= q_next;
            a_r        <= '0;
            b_r        <= $signed({1'b0, keep_den_r});
            cnt_r      <= '0;
            state_r    <= S_DIV_D;
          end else begin
            a_r   <= q_bit ? as_res : as_a;
            b_r   <= $signed({1'b0, q_next});
            cnt_r <= CW'(cnt_r + 1'b1);
          end
        end
        S_DIV_D: begin
          a_r   <= q_bit ? as_res : as_a;
          b_r   <= $signed({1'b0, q_next});
          cnt_r <= CW'(cnt_r + 1'b1);
          if (cnt_r == CW'(MW - 1)) begin
            state_r <= S_NEG;
          end
        end
        S_NEG: begin
          a_r     <= neg_r ? as_res : $signed({1'b0, keep_num_r});
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_result_num_r <= num_ext[rfa_pkg::RESULT_NUM_W-1:0];
            out_result_den_r <= den_ext[rfa_pkg::RESULT_DEN_W-1:0];
            out_order_r      <= order_r;
            out_div_error_r  <= err_r;
            out_valid_r      <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The GCD loop only ever sees two positive operands.
  a_gcd_operands_positive: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GCD |-> (a_r > 0) && (b_r > 0))
    else $error("GCD operand not positive");

  // The division remainder stays below the divisor.
  a_div_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_N || state_r == S_DIV_D) |->
      !a_r[AW-1] && (a_r[MW-1:0] < g_r))
    else $error("division remainder out of range");

  // A waiting result is never overwritten.
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && out_stall |=> state_r == S_DONE)
    else $error("result overwritten while stalled");

  // An error result carries a zero fraction and no order.
  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_div_error_r |->
      out_result_den_r == '0 && out_result_num_r == '0 &&
      out_order_r == rfa_pkg::ORDER_LESS)
    else $error("error result not cleared");

  // A compare order other than less comes only with an empty fraction.
  a_order_only_compare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_order_r != rfa_pkg::ORDER_LESS |->
      out_result_den_r == '0 && !out_div_error_r)
    else $error("order set outside compare");

endmodule

`default_nettype wire

@@ tb/tb_reduced_fraction_alu.sv @@
// Self-checking testbench for the reduced fraction ALU with directed and random words.
`default_nettype none

module tb_reduced_fraction_alu;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OW = rfa_pkg::OPERAND_WIDTH_DEF;

  // Size of the random part. The directed part adds about two dozen words in front of it.
  localparam int RANDOM_WORDS = 1325;

  // Once fewer words than this are waiting to be sent, both sides stop idling.
  localparam int CALM_TAIL = 150;

  // The limit allows for the slowest word at the default width plus the longest
  // sender gap and receiver stall, for each of about 1350 words.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Cycles to watch the output after the last expected result, which is longer than
  // the latency of one word.
  localparam int SETTLE_CYCLES = 300;

  // At most this many mismatches are printed in full.
  localparam int MAX_REPORTS = 10;

  typedef logic [rfa_pkg::MODE_W-1:0]               mode_t;
  typedef logic signed [rfa_pkg::RESULT_NUM_W-1:0]  result_num_t;
  typedef logic [rfa_pkg::RESULT_DEN_W-1:0]         result_den_t;

  // One input word as the driver puts it on the ports. If hold_until_drained is set,
  // the driver waits until every earlier word has produced its result before it
  // offers this one.
  typedef struct {
    mode_t                mode;
    logic signed [OW-1:0] left_num;
    logic [OW-2:0]        left_den;
    logic signed [OW-1:0] right_num;
    logic [OW-2:0]        right_den;
    bit                   hold_until_drained;
  } fraction_word_t;

  typedef struct {
    result_num_t                       num;
    result_den_t                       den;
    logic [rfa_pkg::ORDER_W-1:0]       order;
    logic                              div_error;
  } fraction_result_t;

  // For each accepted word, the queue keeps the word and the result that it should give.
  typedef struct {
    fraction_word_t   word;
    fraction_result_t result;
  } awaited_result_t;

  logic                                    clk = 1'b0;
  logic                                    rst_n = 1'b0;
  logic                                    in_valid = 1'b0;
  logic                                    in_stall;
  mode_t                                   in_mode = '0;
  logic signed [OW-1:0]                    in_left_num = '0;
  logic [OW-2:0]                           in_left_den = '0;
  logic signed [OW-1:0]                    in_right_num = '0;
  logic [OW-2:0]                           in_right_den = '0;
  logic                                    out_valid;
  logic                                    out_stall = 1'b0;
  result_num_t                             out_result_num;
  result_den_t                             out_result_den;
  logic [rfa_pkg::ORDER_W-1:0]             out_order;
  logic                                    out_div_error;

  fraction_word_t  words_to_send[$];
  awaited_result_t awaited_results[$];
  fraction_word_t  word_on_port;
  logic            word_taken = 1'b0;
  int              send_gap = 0;
  int              stall_left = 0;
  int              cycle_count = 0;
  int              error_count = 0;

  reduced_fraction_alu #(
    .OPERAND_WIDTH(OW)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_left_num   (in_left_num),
    .in_left_den   (in_left_den),
    .in_right_num  (in_right_num),
    .in_right_den  (in_right_den),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result_num(out_result_num),
    .out_result_den(out_result_den),
    .out_order     (out_order),
    .out_div_error (out_div_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicts the result word for one input word. Cross products of 16-bit operands
  // fit easily in 64 bits, so the arithmetic here is exact. The result is reduced
  // with Euclid's algorithm, and the outputs keep only their low bits.
  function automatic fraction_result_t predict_fraction(fraction_word_t w);
    longint            ln, ld, rn, rd, num, den, lhs, rhs, signed_num;
    longint unsigned   mag, d, g, b, t;
    bit                neg;
    fraction_result_t  r;
    r.num = '0;
    r.den = '0;
    r.order = rfa_pkg::ORDER_LESS;
    r.div_error = 1'b0;
    ln = longint'(w.left_num);
    ld = longint'(w.left_den);
    rn = longint'(w.right_num);
    rd = longint'(w.right_den);
    num = 0;
    den = 0;
    if (w.mode > rfa_pkg::MODE_CMP) begin
      return r;
    end
    if (w.mode == rfa_pkg::MODE_CMP) begin
      // The cross products are compared as they are. A zero denominator is not
      // treated as a special case here.
      lhs = ln * rd;
      rhs = ld * rn;
      if (lhs > rhs) begin
        r.order = rfa_pkg::ORDER_GREATER;
      end else if (lhs == rhs) begin
        r.order = rfa_pkg::ORDER_EQUAL;
      end else begin
        r.order = rfa_pkg::ORDER_LESS;
      end
      return r;
    end
    case (w.mode)
      rfa_pkg::MODE_ADD: begin
        num = ln * rd + ld * rn;
        den = ld * rd;
      end
      rfa_pkg::MODE_SUB: begin
        num = ln * rd - ld * rn;
        den = ld * rd;
      end
      rfa_pkg::MODE_MUL: begin
        num = ln * rn;
        den = ld * rd;
      end
      default: begin
        num = ln * rd;
        den = ld * rn;
      end
    endcase
    if (den == 0) begin
      r.div_error = 1'b1;
      return r;
    end
    // Only a divide can give a negative denominator. The sign then moves to the numerator.
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    neg = (num < 0);
    mag = neg ? longint'(-num) : longint'(num);
    d = den;
    if (mag == 0) begin
      r.den = result_den_t'(1);
      return r;
    end
    g = mag;
    b = d;
    while (b != 0) begin
      t = g % b;
      g = b;
      b = t;
    end
    mag = mag / g;
    d = d / g;
    signed_num = neg ? -longint'(mag) : longint'(mag);
    r.num = result_num_t'(signed_num);
    r.den = result_den_t'(d);
    return r;
  endfunction

  // Idling changes between bands of words: moderate, none, heavy. Near the end
  // there is none.
  function automatic int idle_percent(int words_left);
    if (words_left < CALM_TAIL) begin
      return 0;
    end
    case ((words_left / 200) % 3)
      0:       return 30;
      1:       return 0;
      default: return 60;
    endcase
  endfunction

  function automatic logic signed [OW-1:0] pick_numerator();
    case ($urandom_range(0, 9)) inside
      0:       return {1'b1, {(OW-1){1'b0}}};
      1:       return {1'b0, {(OW-1){1'b1}}};
      [2:4]:   return OW'($urandom_range(0, 40) - 20);
      default: return OW'($urandom());
    endcase
  endfunction

  // Small denominators share factors often, so results need real reduction. A zero
  // denominator is rare, but it is part of what the field can carry.
  function automatic logic [OW-2:0] pick_denominator();
    case ($urandom_range(0, 49)) inside
      0:       return '0;
      1:       return (OW-1)'(1);
      2:       return {(OW-1){1'b1}};
      [3:17]:  return (OW-1)'($urandom_range(1, 24));
      default: return (OW-1)'($urandom_range(1, (1 << (OW-1)) - 1));
    endcase
  endfunction

  task automatic add_word(input mode_t mode, input int ln, input int ld,
                          input int rn, input int rd);
    fraction_word_t w;
    w.mode = mode;
    w.left_num = OW'(ln);
    w.left_den = (OW-1)'(ld);
    w.right_num = OW'(rn);
    w.right_den = (OW-1)'(rd);
    w.hold_until_drained = 1'b0;
    words_to_send.push_back(w);
  endtask

  // The driver works on the falling edge. A word stays on the port until the rising
  // edge at which it is taken. Only after that does the driver pick the next word,
  // start a gap, or wait for the block to drain.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !word_taken)) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (words_to_send.size() == 0 ||
                   (words_to_send[0].hold_until_drained && awaited_results.size() != 0)) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_percent(words_to_send.size())) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 13);
      end else begin
        word_on_port = words_to_send.pop_front();
        in_valid     <= 1'b1;
        in_mode      <= word_on_port.mode;
        in_left_num  <= word_on_port.left_num;
        in_left_den  <= word_on_port.left_den;
        in_right_num <= word_on_port.right_num;
        in_right_den <= word_on_port.right_den;
      end
    end
  end

  // The receiver stalls in bursts, at the same rate as the sender idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_percent(words_to_send.size())) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // The monitor works on the rising edge. It checks the result word that is taken
  // against the oldest prediction. Then it records the prediction for an input word
  // that is taken at the same edge. Checking comes first so that a new prediction
  // is never matched with an older result.
  always @(posedge clk) begin
    fraction_result_t got;
    awaited_result_t  want;
    cycle_count <= cycle_count + 1;
    word_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      got.num = out_result_num;
      got.den = out_result_den;
      got.order = out_order;
      got.div_error = out_div_error;
      if (awaited_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("Unexpected result word: num %0d den %0d order %0d div_error %0b",
                   got.num, got.den, got.order, got.div_error);
        end
      end else begin
        want = awaited_results.pop_front();
        if (got.num !== want.result.num || got.den !== want.result.den ||
            got.order !== want.result.order || got.div_error !== want.result.div_error) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("Mismatch for mode %0d, %0d/%0d and %0d/%0d:", want.word.mode,
                     want.word.left_num, want.word.left_den, want.word.right_num,
                     want.word.right_den);
            $display("  expected num %0d den %0d order %0d div_error %0b",
                     want.result.num, want.result.den, want.result.order,
                     want.result.div_error);
            $display("  actual   num %0d den %0d order %0d div_error %0b",
                     got.num, got.den, got.order, got.div_error);
          end
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      want.word = word_on_port;
      want.result = predict_fraction(word_on_port);
      awaited_results.push_back(want);
    end
  end

  // A stuck handshake ends the run here.
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int             n;
    fraction_word_t w;

    // Directed words cover the extremes of the operands, every mode, a zero numerator
    // that must come back as 0/1, a divide by a zero fraction, a divide whose
    // denominator turns negative, zero input denominators, and unused modes.
    add_word(rfa_pkg::MODE_ADD, 32767, 1, 32767, 1);
    add_word(rfa_pkg::MODE_ADD, -32768, 1, -32768, 1);
    add_word(rfa_pkg::MODE_ADD, 1, 32767, 1, 32766);
    add_word(rfa_pkg::MODE_ADD, 17711, 28657, 10946, 28657);
    add_word(rfa_pkg::MODE_SUB, 1, 2, 1, 2);
    add_word(rfa_pkg::MODE_SUB, -32768, 32767, 32767, 1);
    add_word(rfa_pkg::MODE_MUL, -32768, 1, -32768, 1);
    add_word(rfa_pkg::MODE_MUL, 32767, 32767, -32768, 32767);
    add_word(rfa_pkg::MODE_MUL, 0, 5, 7, 3);
    add_word(rfa_pkg::MODE_DIV, 3, 4, 0, 9);
    add_word(rfa_pkg::MODE_DIV, 0, 1, 0, 1);
    add_word(rfa_pkg::MODE_DIV, 1, 3, -2, 5);
    add_word(rfa_pkg::MODE_DIV, -32768, 1, -1, 32767);
    add_word(rfa_pkg::MODE_DIV, 6, 35, 10, 21);
    add_word(rfa_pkg::MODE_CMP, 1, 2, 2, 4);
    add_word(rfa_pkg::MODE_CMP, -1, 3, 1, 3);
    add_word(rfa_pkg::MODE_CMP, 32767, 1, -32768, 1);
    add_word(rfa_pkg::MODE_CMP, -32768, 32767, -32768, 32766);
    add_word(rfa_pkg::MODE_ADD, 5, 0, 3, 7);
    add_word(rfa_pkg::MODE_MUL, 5, 3, 3, 0);
    add_word(rfa_pkg::MODE_CMP, 5, 0, -3, 7);
    add_word(3'd5, 1, 2, 3, 4);
    add_word(3'd6, -32768, 32767, 32767, 32767);
    add_word(3'd7, 32767, 1, -1, 1);

    // The random part mostly uses the five defined modes. About one word in sixteen
    // uses an unused mode.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      n = $urandom_range(0, 31);
      w.mode = (n < 30) ? mode_t'(n % 5) : mode_t'($urandom_range(5, 7));
      w.left_num = pick_numerator();
      w.left_den = pick_denominator();
      w.right_num = pick_numerator();
      w.right_den = pick_denominator();
      // The sender lets the block drain fully after the directed part and again
      // partway through the random part.
      w.hold_until_drained = (i == 0) || (i == RANDOM_WORDS / 2);
      words_to_send.push_back(w);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_to_send.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ reduced_fraction_alu.f @@
hdl/rfa_pkg.sv
hdl/reduced_fraction_alu.sv
tb/tb_reduced_fraction_alu.sv
